### rtl/core/kmd_pkg.sv
// Shared types and constants for the key matrix debouncer.
`default_nettype none

package kmd_pkg;

	localparam int KEY_W  = 8;
	localparam int TIME_W = 32;
	localparam int DEB_W  = 8;
	localparam int IDX_W  = 3;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd5;

	typedef enum logic [3:0] {
		PH_IDLE           = 4'b0001,
		PH_MAYBE_PRESSED  = 4'b0010,
		PH_PRESSED        = 4'b0100,
		PH_MAYBE_RELEASED = 4'b1000
	} kmd_phase_t;

	typedef struct packed {
		logic [KEY_W-1:0] debounced_keys;
		logic [KEY_W-1:0] new_presses;
		logic             new_press_found;
		logic [IDX_W-1:0] new_press_index;
	} kmd_result_t;

endpackage

`default_nettype wire

### rtl/core/kmd_if.sv
// Handshake channels of the key matrix debouncer: scan words, result words, config writes.
`default_nettype none

interface kmd_scan_if;
	logic        valid;
	logic        ready;
	logic [7:0]  key_levels;
	logic [31:0] now_ms;

	modport source (output valid, output key_levels, output now_ms, input ready);
	modport sink (input valid, input key_levels, input now_ms, output ready);
endinterface

interface kmd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] debounced_keys;
	logic [7:0] new_presses;
	logic       new_press_found;
	logic [2:0] new_press_index;

	modport source (output valid, output debounced_keys, output new_presses,
		output new_press_found, output new_press_index, input ready);
	modport sink (input valid, input debounced_keys, input new_presses,
		input new_press_found, input new_press_index, output ready);
endinterface

interface kmd_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] debounce_time;

	modport source (output valid, output debounce_time, input ready);
	modport sink (input valid, input debounce_time, output ready);
endinterface

`default_nettype wire

### rtl/core/kmd_lane.sv
// One key's debounce state machine with its phase start timestamp.
`default_nettype none

module kmd_lane
	import kmd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              closed,
	input  wire logic [TIME_W-1:0] now_ms,
	input  wire logic [DEB_W-1:0]  debounce_time,
	output logic                   pressed
);

	kmd_phase_t        phase_q, phase_d;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] age;
	logic              elapsed;
	logic              restart;

	// wrap-around age of the current phase
	assign age     = now_ms - start_q;
	assign elapsed = age >= {{(TIME_W-DEB_W){1'b0}}, debounce_time};

	always_comb begin
		phase_d = phase_q;
		pressed = 1'b0;
		restart = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (closed) begin
					phase_d = PH_MAYBE_PRESSED;
					restart = 1'b1;
				end
			end
			PH_MAYBE_PRESSED: begin
				if (!closed) begin
					phase_d = PH_IDLE;
				end else if (elapsed) begin
					phase_d = PH_PRESSED;
					pressed = 1'b1;
				end
			end
			PH_PRESSED: begin
				if (!closed) begin
					phase_d = PH_MAYBE_RELEASED;
					restart = 1'b1;
				end else begin
					pressed = 1'b1;
				end
			end
			PH_MAYBE_RELEASED: begin
				if (closed) begin
					phase_d = PH_PRESSED;
					pressed = 1'b1;
				end else if (elapsed) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			start_q <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			if (restart) begin
				start_q <= now_ms;
			end
		end
	end

`ifndef SYNTH
	a_idle_never_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> !pressed)
		else $error("idle key reported as pressed");
	a_pressed_needs_contact: assert property (@(posedge clk) disable iff (!arst_n)
		pressed |-> closed)
		else $error("key pressed with contact open");
	a_press_starts_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(en && phase_q == PH_IDLE && closed)
		|=> (phase_q == PH_MAYBE_PRESSED && start_q == $past(now_ms)))
		else $error("press did not start debounce timer");
`endif

endmodule

`default_nettype wire

### rtl/core/kmd_merge.sv
// Merges lane results: edge detect, lowest new press, output register with skid.
`default_nettype none

module kmd_merge
	import kmd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [KEY_W-1:0] deb,
	output logic                  can_take,
	kmd_result_if.source          result
);

	logic [KEY_W-1:0] last_q;
	kmd_result_t      res;
	kmd_result_t      main_q, skid_q;
	logic             main_v_q, skid_v_q;
	logic             pop;

	always_comb begin
		res.debounced_keys  = deb;
		res.new_presses     = deb & ~last_q;
		res.new_press_found = |res.new_presses;
		res.new_press_index = '0;
		// scan downward so the lowest set bit wins
		for (int i = KEY_W - 1; i >= 0; i--) begin
			if (res.new_presses[i]) begin
				res.new_press_index = IDX_W'(i);
			end
		end
	end

	assign pop      = main_v_q && result.ready;
	assign can_take = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (push) begin
				last_q <= deb;
			end
			if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else if (!push) begin
					main_v_q <= 1'b0;
				end
			end else if (push) begin
				if (!main_v_q) begin
					main_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_v_q) begin
			main_q <= skid_q;
		end else if (push && (pop || !main_v_q)) begin
			main_q <= res;
		end
		if (push && main_v_q && !pop) begin
			skid_q <= res;
		end
	end

	assign result.valid           = main_v_q;
	assign result.debounced_keys  = main_q.debounced_keys;
	assign result.new_presses     = main_q.new_presses;
	assign result.new_press_found = main_q.new_press_found;
	assign result.new_press_index = main_q.new_press_index;

`ifndef SYNTH
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid word held with empty output register");
	a_history_follows_scan: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (last_q == $past(deb)))
		else $error("previous debounced keys not updated");
	a_index_points_at_press: assert property (@(posedge clk) disable iff (!arst_n)
		(main_v_q && main_q.new_press_found)
		|-> main_q.new_presses[main_q.new_press_index])
		else $error("new press index does not mark a new press");
`endif

endmodule

`default_nettype wire

### rtl/core/key_matrix_debouncer.sv
// The result word for a scan is registered in the output register, or in the skid stage while an earlier result waits.
// One scan word per cycle while the skid stage is empty; every key lane finishes its step as the word is accepted.
// A two-word output register and skid stage lets a scan in while a result waits.
// Reset (arst_n low): all keys idle, timestamps and previous keys zero, debounce 5 ms,
// no result pending. Nothing needs clearing after reset.
`default_nettype none

module key_matrix_debouncer
	import kmd_pkg::*;
#(
	parameter int ROWS = 2,
	parameter int COLS = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	kmd_scan_if.sink     scan,
	kmd_cfg_if.sink      cfg,
	kmd_result_if.source result
);

	localparam int NKEYS = (ROWS * COLS > KEY_W) ? KEY_W : ROWS * COLS;

	logic [DEB_W-1:0] debounce_time_q;
	logic [KEY_W-1:0] deb;
	logic             can_take;
	logic             push;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_time_q <= DEBOUNCE_RESET;
		end else if (cfg.valid) begin
			debounce_time_q <= cfg.debounce_time;
		end
	end

	assign scan.ready = can_take;
	assign push       = scan.valid && can_take;

	for (genvar g = 0; g < KEY_W; g++) begin : g_key
		if (g < NKEYS) begin : g_lane
			kmd_lane u_lane (
				.clk           (clk),
				.arst_n        (arst_n),
				.en            (push),
				.closed        (scan.key_levels[g]),
				.now_ms        (scan.now_ms),
				.debounce_time (debounce_time_q),
				.pressed       (deb[g])
			);
		end else begin : g_unused
			// keys outside the matrix never press
			assign deb[g] = 1'b0;
		end
	end

	kmd_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.deb      (deb),
		.can_take (can_take),
		.result   (result)
	);

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for key_matrix_debouncer: scan words against a per-key debounce model.

module tb;
	import kmd_pkg::*;

	localparam int ROWS        = 2;
	localparam int COLS        = 4;
	localparam int SCAN_KEYS   = (ROWS * COLS > KEY_W) ? KEY_W : ROWS * COLS;
	localparam int IDLE_PCT    = 28;
	localparam int HOLD_CYCLES = 64;
	localparam int PHASE_ITEMS = 172;

	class debounce_checker;
		kmd_phase_t        key_state[KEY_W];
		logic [TIME_W-1:0] state_since[KEY_W];
		logic [KEY_W-1:0]  prev_keys;
		logic [DEB_W-1:0]  debounce_ms;
		kmd_result_t       awaited_words[$];
		int                errors;

		function new();
			for (int k = 0; k < KEY_W; k++) begin
				key_state[k]   = PH_IDLE;
				state_since[k] = '0;
			end
			prev_keys   = '0;
			debounce_ms = DEBOUNCE_RESET;
			errors      = 0;
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function void set_debounce(logic [DEB_W-1:0] ms);
			debounce_ms = ms;
		endfunction

		function int pending();
			return awaited_words.size();
		endfunction

		// Step every key machine on one accepted scan word and queue the expected result.
		function void note_scan(logic [KEY_W-1:0] levels, logic [TIME_W-1:0] now);
			kmd_result_t      exp_word;
			logic [KEY_W-1:0] keys;
			logic [TIME_W-1:0] age;
			logic             closed;
			logic             settled;

			keys = '0;
			for (int k = 0; k < SCAN_KEYS; k++) begin
				closed  = levels[k];
				age     = now - state_since[k];
				settled = age >= TIME_W'(debounce_ms);
				case (key_state[k])
					PH_IDLE: begin
						if (closed) begin
							key_state[k]   = PH_MAYBE_PRESSED;
							state_since[k] = now;
						end
					end
					PH_MAYBE_PRESSED: begin
						if (!closed)
							key_state[k] = PH_IDLE;
						else if (settled) begin
							key_state[k] = PH_PRESSED;
							keys[k]      = 1'b1;
						end
					end
					PH_PRESSED: begin
						if (closed)
							keys[k] = 1'b1;
						else begin
							key_state[k]   = PH_MAYBE_RELEASED;
							state_since[k] = now;
						end
					end
					default: begin
						if (closed) begin
							key_state[k] = PH_PRESSED;
							keys[k]      = 1'b1;
						end else if (settled)
							key_state[k] = PH_IDLE;
					end
				endcase
			end
			exp_word.debounced_keys  = keys;
			exp_word.new_presses     = keys & ~prev_keys;
			exp_word.new_press_found = |exp_word.new_presses;
			exp_word.new_press_index = '0;
			for (int k = KEY_W - 1; k >= 0; k--)
				if (exp_word.new_presses[k])
					exp_word.new_press_index = IDX_W'(k);
			prev_keys = keys;
			awaited_words.push_back(exp_word);
		endfunction

		task check_result(kmd_result_t got);
			kmd_result_t exp_word;

			if (awaited_words.size() == 0) begin
				report("result word with nothing expected");
				return;
			end
			exp_word = awaited_words.pop_front();
			if (got.debounced_keys !== exp_word.debounced_keys)
				report($sformatf("debounced_keys %h, expected %h",
					got.debounced_keys, exp_word.debounced_keys));
			if (got.new_presses !== exp_word.new_presses)
				report($sformatf("new_presses %h, expected %h",
					got.new_presses, exp_word.new_presses));
			if (got.new_press_found !== exp_word.new_press_found)
				report($sformatf("new_press_found %b, expected %b",
					got.new_press_found, exp_word.new_press_found));
			if (got.new_press_index !== exp_word.new_press_index)
				report($sformatf("new_press_index %0d, expected %0d",
					got.new_press_index, exp_word.new_press_index));
		endtask
	endclass

	logic clk;
	logic arst_n;

	kmd_scan_if   scan();
	kmd_cfg_if    cfg();
	kmd_result_if result();

	key_matrix_debouncer #(
		.ROWS(ROWS),
		.COLS(COLS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.scan  (scan),
		.cfg   (cfg),
		.result(result)
	);

	debounce_checker sb = new();

	bit                gaps_on;
	bit                hold_req;
	logic [TIME_W-1:0] cur_time;
	logic [KEY_W-1:0]  cur_levels;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

	// Result side: check every accepted word, stall at random or hold off on request.
	initial begin : result_sink
		kmd_result_t got;

		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) begin
				got.debounced_keys  = result.debounced_keys;
				got.new_presses     = result.new_presses;
				got.new_press_found = result.new_press_found;
				got.new_press_index = result.new_press_index;
				sb.check_result(got);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				result.ready <= 1'b1;
			end else
				result.ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	task automatic send_scan(input logic [KEY_W-1:0] levels, input logic [TIME_W-1:0] now);
		while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
			scan.valid <= 1'b0;
			@(posedge clk);
		end
		scan.valid      <= 1'b1;
		scan.key_levels <= levels;
		scan.now_ms     <= now;
		@(posedge clk);
		while (!scan.ready)
			@(posedge clk);
		sb.note_scan(levels, now);
	endtask

	// Drop valid and wait until every expected result word has come back.
	task automatic drain();
		scan.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_debounce(input logic [DEB_W-1:0] ms);
		drain();
		cfg.valid         <= 1'b1;
		cfg.debounce_time <= ms;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		sb.set_debounce(ms);
	endtask

	// Mostly a coherent key history with slowly advancing time; some noise and time jumps.
	task automatic run_random(input int n_items, input int step_max, input int hold_at);
		logic [KEY_W-1:0] flips;
		int               roll;

		for (int n = 0; n < n_items; n++) begin
			if (n == hold_at)
				hold_req = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 8)
				send_scan(KEY_W'($urandom), TIME_W'($urandom));
			else begin
				if (roll < 11)
					cur_time = TIME_W'($urandom);
				else if (roll < 15)
					cur_time += TIME_W'($urandom_range(0, 3 * step_max + 10));
				else
					cur_time += TIME_W'($urandom_range(0, step_max));
				flips = '0;
				for (int b = 0; b < KEY_W; b++)
					flips[b] = ($urandom_range(0, 7) == 0);
				cur_levels ^= flips;
				send_scan(cur_levels, cur_time);
			end
		end
	endtask

	initial begin : stimulus
		logic [DEB_W-1:0] ms;

		arst_n            <= 1'b0;
		scan.valid        <= 1'b0;
		scan.key_levels   <= '0;
		scan.now_ms       <= '0;
		cfg.valid         <= 1'b0;
		cfg.debounce_time <= '0;
		gaps_on  = 1'b1;
		hold_req = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset debounce time: press, bounce, release, wrap of the timestamp.
		send_scan(8'h00, 32'd0);
		send_scan(8'hFF, 32'd0);
		send_scan(8'hFF, 32'd3);
		send_scan(8'hFF, 32'd5);
		send_scan(8'hFE, 32'd6);
		send_scan(8'hFF, 32'd7);
		send_scan(8'h7F, 32'd8);
		send_scan(8'h7F, 32'd20);
		send_scan(8'hFF, 32'd21);
		send_scan(8'hFF, 32'd30);
		send_scan(8'h00, 32'd31);
		send_scan(8'h00, 32'd40);
		send_scan(8'h10, 32'hFFFF_FFFE);
		send_scan(8'h10, 32'h0000_0003);
		send_scan(8'h30, 32'd4);
		send_scan(8'h10, 32'd5);
		send_scan(8'h00, 32'hFFFF_FFFF);

		// Zero debounce: a maybe phase resolves on the next scan.
		write_debounce(8'd0);
		send_scan(8'h01, 32'd100);
		send_scan(8'h01, 32'd100);
		send_scan(8'h00, 32'd100);
		send_scan(8'h00, 32'd100);

		// Longest debounce: one millisecond short, then just enough.
		write_debounce(8'd255);
		send_scan(8'h80, 32'd200);
		send_scan(8'h80, 32'd454);
		send_scan(8'h80, 32'd455);
		send_scan(8'h00, 32'd455);

		cur_time   = 32'd1000;
		cur_levels = '0;

		for (int p = 0; p < 8; p++) begin
			case (p)
				0:       ms = DEBOUNCE_RESET;
				1:       ms = 8'd0;
				2:       ms = 8'd1;
				3:       ms = 8'd255;
				4:       ms = 8'd3;
				5:       ms = 8'd2;
				default: ms = DEB_W'($urandom_range(4, 254));
			endcase
			write_debounce(ms);
			// Keep both sides busy, with no gaps, for the whole first phase; later phases insert random gaps.
			gaps_on = (p != 0);
			run_random(PHASE_ITEMS, ms / 3 + 2, (p == 1) ? PHASE_ITEMS / 2 : -1);
		end
		gaps_on = 1'b1;

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
